// File: rtl/core/qpr_pkg.sv
package qpr_pkg;

   localparam int WORD_W     = 32;
   localparam int ANGLE_W    = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE    = 3'd6;

   // Angle constants in Q2.30, held in 37 bits to cover the scaled 21 bit angle.
   localparam logic signed [36:0] PI_Q30      = 37'sd3373259426;
   localparam logic signed [36:0] HALF_PI_Q30 = 37'sd1686629713;
   localparam logic signed [36:0] TWO_PI_Q30  = 37'sd6746518852;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   typedef struct packed {
      logic signed [WORD_W-1:0]  axis_x;
      logic signed [WORD_W-1:0]  axis_y;
      logic signed [WORD_W-1:0]  axis_z;
      logic signed [WORD_W-1:0]  center_x;
      logic signed [WORD_W-1:0]  center_y;
      logic signed [WORD_W-1:0]  center_z;
      logic signed [ANGLE_W-1:0] angle;
   } cfg_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] r;
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
      logic signed [WORD_W-1:0] z;
   } rotor_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] z;
      logic signed [WORD_W-1:0] y;
      logic signed [WORD_W-1:0] x;
   } point_type;

   // Truncated atan(2^-i) in Q2.30.
   function automatic logic signed [36:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         5'd31: v = 32'h00000000;
      endcase
      return $signed({5'd0, v});
   endfunction

   // Low 48 bits of a signed 32 by 32 product; enough for a wrapped Q16.16 result.
   function automatic logic [47:0] mul48(input logic signed [WORD_W-1:0] a,
                                         input logic signed [WORD_W-1:0] b);
      logic signed [63:0] full;
      full = a * b;
      return full[47:0];
   endfunction

   // Q16.16 rounding of a product: (p + 2^15) >> 16, kept to 32 bits.
   function automatic logic [WORD_W-1:0] rnd16(input logic [47:0] p);
      logic [47:0] s;
      s = p + 48'd32768;
      return s[47:16];
   endfunction

endpackage

// File: rtl/core/qpr_rotor.sv
module qpr_rotor import qpr_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wr_data,
   output cfg_type              cfg,
   output rotor_type            rotor,
   output logic                 busy
);

   localparam int RUN_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam logic [5:0] LAST_STEP = 6'(RUN_STEPS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_REDUCE = 3'd2;
   localparam logic [2:0] ST_CORDIC = 3'd3;
   localparam logic [2:0] ST_MULT   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   // Register values after reset: unit z axis, zero centre and angle.
   localparam cfg_type CFG_RESET = cfg_type'{32'sd0, 32'sd0, 32'sd65536,
                                             32'sd0, 32'sd0, 32'sd0, 21'sd0};
   // Identity quaternion.
   localparam rotor_type ROTOR_RESET = rotor_type'{32'sd65536, 32'sd0, 32'sd0, 32'sd0};

   cfg_type            cfg_ff, cfg_in;
   rotor_type          rotor_ff, rotor_in;
   logic [2:0]         state_ff, state_in;
   logic signed [36:0] h_ff, h_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic               neg_ff, neg_in;
   logic [5:0]         step_ff, step_in;
   logic signed [65:0] pm_x_ff, pm_x_in, pm_y_ff, pm_y_in, pm_z_ff, pm_z_in;

   logic signed [33:0] dx, dy, cx_fin;
   logic signed [34:0] r_sum;
   logic signed [65:0] wx, wy, wz;

   always_comb begin
      cfg_in   = cfg_ff;
      rotor_in = rotor_ff;
      state_in = state_ff;
      h_in     = h_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      pm_x_in  = pm_x_ff;
      pm_y_in  = pm_y_ff;
      pm_z_in  = pm_z_ff;
      dx       = cy_ff >>> step_ff[4:0];
      dy       = cx_ff >>> step_ff[4:0];
      cx_fin   = neg_ff ? -cx_ff : cx_ff;
      r_sum    = 35'(cx_fin) + 35'sd8192;
      wx       = pm_x_ff + 66'sd536870912;
      wy       = pm_y_ff + 66'sd536870912;
      wz       = pm_z_ff + 66'sd536870912;

      unique case (state_ff)
         ST_LOAD: begin
            h_in     = $signed({{3{cfg_ff.angle[ANGLE_W-1]}}, cfg_ff.angle, 13'd0});
            cx_in    = GAIN_Q30;
            cy_in    = '0;
            neg_in   = 1'b0;
            step_in  = '0;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            // Wrap into [-pi, pi) one turn a cycle, then fold into the right half plane.
            priority if (h_ff >= PI_Q30) begin
               h_in = h_ff - TWO_PI_Q30;
            end else if (h_ff < -PI_Q30) begin
               h_in = h_ff + TWO_PI_Q30;
            end else begin
               if (h_ff > HALF_PI_Q30) begin
                  h_in   = PI_Q30 - h_ff;
                  neg_in = 1'b1;
               end else if (h_ff < -HALF_PI_Q30) begin
                  h_in   = -PI_Q30 - h_ff;
                  neg_in = 1'b1;
               end
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (h_ff >= 0) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               h_in  = h_ff - atan_q30(step_ff[4:0]);
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               h_in  = h_ff + atan_q30(step_ff[4:0]);
            end
            step_in = step_ff + 6'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            pm_x_in  = cy_ff * cfg_ff.axis_x;
            pm_y_in  = cy_ff * cfg_ff.axis_y;
            pm_z_in  = cy_ff * cfg_ff.axis_z;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rotor_in.r = 32'(r_sum >>> 14);
            rotor_in.x = wx[61:30];
            rotor_in.y = wy[61:30];
            rotor_in.z = wz[61:30];
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write restarts the rotor build from the fresh values.
      if (csr_wr_en && csr_index <= REG_ANGLE) begin
         unique case (csr_index)
            REG_AXIS_X:   cfg_in.axis_x   = csr_wr_data;
            REG_AXIS_Y:   cfg_in.axis_y   = csr_wr_data;
            REG_AXIS_Z:   cfg_in.axis_z   = csr_wr_data;
            REG_CENTER_X: cfg_in.center_x = csr_wr_data;
            REG_CENTER_Y: cfg_in.center_y = csr_wr_data;
            REG_CENTER_Z: cfg_in.center_z = csr_wr_data;
            default:      cfg_in.angle    = csr_wr_data[ANGLE_W-1:0];
         endcase
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         rotor_ff <= ROTOR_RESET;
         state_ff <= ST_IDLE;
      end else begin
         cfg_ff   <= cfg_in;
         rotor_ff <= rotor_in;
         state_ff <= state_in;
      end
      h_ff    <= h_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      pm_x_ff <= pm_x_in;
      pm_y_ff <= pm_y_in;
      pm_z_ff <= pm_z_in;
   end

   assign cfg   = cfg_ff;
   assign rotor = rotor_ff;
   assign busy  = (state_ff != ST_IDLE);

endmodule

// File: rtl/core/qpr_front.sv
module qpr_front import qpr_pkg::*; (
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,
   input  logic         busy,
   input  logic         queue_ready,
   input  cfg_type      cfg,
   output logic         push,
   output point_type    entry
);

   // Requests wait while the rotor is being rebuilt or the queue is full.
   assign req_tready = !busy && queue_ready;
   assign push       = req_tvalid && req_tready;

   assign entry.x = $signed(req_tdata[31:0])  - cfg.center_x;
   assign entry.y = $signed(req_tdata[63:32]) - cfg.center_y;
   assign entry.z = $signed(req_tdata[95:64]) - cfg.center_z;

endmodule

// File: rtl/core/qpr_queue.sv
module qpr_queue import qpr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type push_data,
   output logic      push_ready,
   input  logic      pop,
   output logic      pop_valid,
   output point_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   point_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !pop_valid |-> !pop)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a write");
`endif

endmodule

// File: rtl/core/qpr_back.sv
module qpr_back import qpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  point_type   q_data,
   output logic        pop,
   input  rotor_type   rotor,
   input  cfg_type     cfg,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata
);

   logic               adv;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [47:0]        m1_ff [12];
   logic [47:0]        m1_in [12];
   logic [47:0]        m2_ff [12];
   logic [47:0]        m2_in [12];
   logic signed [31:0] tr_ff, tx_ff, ty_ff, tz_ff;
   logic signed [31:0] tr_in, tx_in, ty_in, tz_in;
   logic [95:0]        out_ff, out_in;
   logic signed [31:0] nx, ny, nz;

   assign adv = !v4_ff || rsp_tready;
   assign pop = q_valid && adv;

   // Conjugate words, wrapped.
   assign nx = -rotor.x;
   assign ny = -rotor.y;
   assign nz = -rotor.z;

   always_comb begin
      logic [31:0] rx, ry, rz;
      // t = q * (0, p): products.
      m1_in[0]  = mul48(rotor.x, q_data.x);
      m1_in[1]  = mul48(rotor.y, q_data.y);
      m1_in[2]  = mul48(rotor.z, q_data.z);
      m1_in[3]  = mul48(rotor.r, q_data.x);
      m1_in[4]  = mul48(rotor.y, q_data.z);
      m1_in[5]  = mul48(rotor.z, q_data.y);
      m1_in[6]  = mul48(rotor.r, q_data.y);
      m1_in[7]  = mul48(rotor.x, q_data.z);
      m1_in[8]  = mul48(rotor.z, q_data.x);
      m1_in[9]  = mul48(rotor.r, q_data.z);
      m1_in[10] = mul48(rotor.x, q_data.y);
      m1_in[11] = mul48(rotor.y, q_data.x);
      // t sums.
      tr_in = -rnd16(m1_ff[0]) - rnd16(m1_ff[1]) - rnd16(m1_ff[2]);
      tx_in = rnd16(m1_ff[3]) + rnd16(m1_ff[4]) - rnd16(m1_ff[5]);
      ty_in = rnd16(m1_ff[6]) - rnd16(m1_ff[7]) + rnd16(m1_ff[8]);
      tz_in = rnd16(m1_ff[9]) + rnd16(m1_ff[10]) - rnd16(m1_ff[11]);
      // t * conj(q): products for the vector part.
      m2_in[0]  = mul48(tr_ff, nx);
      m2_in[1]  = mul48(tx_ff, rotor.r);
      m2_in[2]  = mul48(ty_ff, nz);
      m2_in[3]  = mul48(tz_ff, ny);
      m2_in[4]  = mul48(tr_ff, ny);
      m2_in[5]  = mul48(tx_ff, nz);
      m2_in[6]  = mul48(ty_ff, rotor.r);
      m2_in[7]  = mul48(tz_ff, nx);
      m2_in[8]  = mul48(tr_ff, nz);
      m2_in[9]  = mul48(tx_ff, ny);
      m2_in[10] = mul48(ty_ff, nx);
      m2_in[11] = mul48(tz_ff, rotor.r);
      // Final sums with the centre added back.
      rx = rnd16(m2_ff[0]) + rnd16(m2_ff[1]) + rnd16(m2_ff[2]) - rnd16(m2_ff[3]);
      ry = rnd16(m2_ff[4]) - rnd16(m2_ff[5]) + rnd16(m2_ff[6]) + rnd16(m2_ff[7]);
      rz = rnd16(m2_ff[8]) + rnd16(m2_ff[9]) - rnd16(m2_ff[10]) + rnd16(m2_ff[11]);
      out_in = {rz + cfg.center_z, ry + cfg.center_y, rx + cfg.center_x};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (adv) begin
         m1_ff  <= m1_in;
         tr_ff  <= tr_in;
         tx_ff  <= tx_in;
         ty_ff  <= ty_in;
         tz_ff  <= tz_in;
         m2_ff  <= m2_in;
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = out_ff;

endmodule

// File: rtl/core/quaternion_point_rotation_unit.sv
// Channel   Direction  Payload
// req_      in         tdata[95:0] = point_x, point_y, point_z (x lowest)
// rsp_      out        tdata[95:0] = rotated_x, rotated_y, rotated_z (x lowest)
// csr_      in         write only: csr_index selects one of seven registers
//
// A request passes through a two entry queue and then the back end, a four
// stage multiply/add pipeline; one point is accepted every cycle unless the
// rotor is being rebuilt or the queue is full.
// A register write rebuilds the rotor in order: load, angle reduction,
// CORDIC_STEPS (at most 32) iterations of the CORDIC, axis products and
// rounding; requests are held off meanwhile.
// Reset is synchronous; it restores the identity rotor with no CORDIC pass.
// A stalled response stalls the pipeline; the queue absorbs two more requests.
module quaternion_point_rotation_unit import qpr_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [95:0]          req_tdata,   // point_x, point_y, point_z
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,   // rotated_x, rotated_y, rotated_z
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wr_data
);

   cfg_type   cfg;
   rotor_type rotor;
   logic      busy;
   logic      push, queue_ready, pop, q_valid;
   point_type entry, q_data;

   // The rotor unit holds the registers and forms the quaternion from them.
   qpr_rotor #(.CORDIC_STEPS(CORDIC_STEPS)) u_rotor (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .cfg        (cfg),
      .rotor      (rotor),
      .busy       (busy)
   );

   // The front end takes requests and moves each point into the centre frame.
   qpr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .busy       (busy),
      .queue_ready(queue_ready),
      .cfg        (cfg),
      .push       (push),
      .entry      (entry)
   );

   qpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .push_ready(queue_ready),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   // The back end applies q * p * conj(q) and adds the centre back.
   qpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop),
      .rotor     (rotor),
      .cfg       (cfg),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_hold_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("request accepted during rotor rebuild");
   a_write_starts_build: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && csr_index <= REG_ANGLE) |=> busy)
      else $error("register write did not start a rotor rebuild");
   a_clean_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && !busy))
      else $error("response or rebuild active right after reset");
`endif

endmodule
